// ===== sv/sbc_bitpool_search_core_assert.svh =====
// Assertion macros shared by the bitpool search checker.
`ifndef SBC_BITPOOL_SEARCH_CORE_ASSERT_SVH
`define SBC_BITPOOL_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication under clock and active-low reset.
`define SBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitpool search assertion failed");

// Next-cycle implication under clock and active-low reset.
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitpool search assertion failed");

`endif

// ===== sv/sbc_bps_pkg.sv =====
// Constants and register codes of the SBC bitpool search block.
package sbc_bps_pkg;

  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_SUBBANDS    = 2'd1;
  localparam logic [1:0] CFG_BLOCKS      = 2'd2;
  localparam logic [1:0] CFG_CHAN_MODE   = 2'd3;

  localparam logic [1:0] MODE_MONO  = 2'd0;
  localparam logic [1:0] MODE_DUAL  = 2'd1;
  localparam logic [1:0] MODE_STERE = 2'd2;
  localparam logic [1:0] MODE_JOINT = 2'd3;

  localparam logic [1:0] MOVED_DOWN = 2'b01;
  localparam logic [1:0] MOVED_UP   = 2'b10;
  localparam logic [1:0] MOVED_BOTH = 2'b11;

  localparam logic [15:0] RATE_STEP = 16'd5;
  localparam logic [7:0]  HDR_BITS  = 8'd32;

  // Bit positions of the result beat.
  localparam int unsigned OUT_CAUSE_BIT = 32;

endpackage

// ===== sv/sbc_bitpool_search_core.sv =====
// SBC bitpool search: iterative rate stepping with a bit-serial divider.
// One beat in gives one beat out. Each search iteration runs up to three
// divisions, two for mono and dual channel and three for stereo and joint
// stereo, through a single restoring divider that retires one quotient bit
// per cycle over a 36-bit dividend; a whole search repeats the iteration,
// stepping the rate by 5 kbps while the pool misses its range. A new beat is
// taken only once the previous search has finished. Configuration writes are
// taken every cycle.
module sbc_bitpool_search_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] start_rate_kbps, [23:16] min_pool, [31:24] max_pool
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] pool_value, [31:16] final_rate_kbps, [32] stop_cause, [39:33] zero
  output logic [39:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_A_SETUP, S_B_SETUP, S_POOL, S_FRAME, S_C_SETUP,
    S_DIV, S_CHECK, S_DECIDE, S_DONE
  } state_t;

  state_t      state_r, div_ret_r;
  logic [15:0] fs_r;
  logic [3:0]  sb_r;
  logic [4:0]  nb_r;
  logic [1:0]  mode_r;
  logic [15:0] rate_r;
  logic [7:0]  lo_r, hi_r;
  logic [1:0]  moved_r;
  logic [15:0] q1_r, pool_r, frame_r;
  logic        cause_r;
  logic        out_tvalid_r;
  logic [39:0] out_tdata_r;

  // divider
  logic [35:0] div_dq_r;
  logic [18:0] div_rem_r, div_den_r;
  logic [5:0]  div_cnt_r;
  logic        div_neg_r;

  logic        stereo;
  logic [3:0]  joint;
  logic [13:0] sb_k;
  logic [29:0] prod_a;
  logic [18:0] den_a;
  logic [7:0]  num_b;
  logic [8:0]  sbnb;
  logic [18:0] den_c;
  logic signed [32:0] prod_c;
  logic signed [35:0] num_c;
  logic [35:0] mag_c;
  logic signed [22:0] frame_t;
  logic signed [22:0] frame_d;
  logic [15:0] frame_nxt;
  logic [19:0] rem_sh;
  logic        rem_ge;
  logic [18:0] rem_nxt;
  logic [15:0] div_q16;
  logic [16:0] rate_up;
  logic [1:0]  moved_nxt;
  logic        zero_div;

  assign stereo   = (mode_r == sbc_bps_pkg::MODE_STERE) || (mode_r == sbc_bps_pkg::MODE_JOINT);
  assign joint    = (mode_r == sbc_bps_pkg::MODE_JOINT) ? sb_r : 4'd0;
  assign zero_div = (fs_r == 16'd0) || (sb_r == 4'd0) || (nb_r == 5'd0);

  assign sb_k   = 14'({10'd0, sb_r} * 14'd1000);
  assign prod_a = 30'({14'd0, rate_r} * {16'd0, sb_k});
  assign den_a  = (mode_r == sbc_bps_pkg::MODE_MONO || stereo) ? {3'd0, fs_r}
                                                               : {2'd0, fs_r, 1'b0};

  // Constant part of the pool formula, divided by the block count.
  always_comb begin
    if (stereo) begin
      num_b = sbc_bps_pkg::HDR_BITS + {1'b0, sb_r, 3'd0} + {4'd0, joint};
    end else if (mode_r == sbc_bps_pkg::MODE_MONO) begin
      num_b = sbc_bps_pkg::HDR_BITS + {2'd0, sb_r, 2'd0};
    end else begin
      num_b = (sbc_bps_pkg::HDR_BITS >> 1) + {2'd0, sb_r, 2'd0};
    end
  end

  assign sbnb   = 9'({5'd0, sb_r} * {4'd0, nb_r});
  assign den_c  = 19'({10'd0, sbnb} * 19'd1000);
  assign prod_c = $signed({{17{frame_r[15]}}, frame_r}) * $signed({17'd0, fs_r});
  assign num_c  = {prod_c[32], prod_c[31:0], 3'd0};
  assign mag_c  = num_c[35] ? 36'(-num_c) : 36'(num_c);

  // Frame length: truncate toward zero on the joint-plus-pool term.
  assign frame_t   = 23'($signed({{7{pool_r[15]}}, pool_r}) * $signed({18'd0, nb_r}))
                     + $signed({19'd0, joint});
  assign frame_d   = frame_t[22] ? ((frame_t + 23'sd7) >>> 3) : (frame_t >>> 3);
  assign frame_nxt = 16'(frame_d) + 16'd4 + {12'd0, sb_r};

  assign rem_sh  = {div_rem_r, div_dq_r[35]};
  assign rem_ge  = rem_sh >= {1'b0, div_den_r};
  assign rem_nxt = rem_ge ? 19'(rem_sh - {1'b0, div_den_r}) : rem_sh[18:0];
  assign div_q16 = div_neg_r ? 16'(~div_dq_r[15:0] + 16'd1) : div_dq_r[15:0];

  assign rate_up = {1'b0, rate_r} + {1'b0, sbc_bps_pkg::RATE_STEP};

  always_comb begin
    moved_nxt = moved_r;
    if ($signed(pool_r) > $signed({8'd0, hi_r})) begin
      moved_nxt = moved_r | sbc_bps_pkg::MOVED_DOWN;
    end else if ($signed(pool_r) < $signed({8'd0, lo_r})) begin
      moved_nxt = rate_up[16] ? sbc_bps_pkg::MOVED_BOTH : (moved_r | sbc_bps_pkg::MOVED_UP);
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      div_ret_r    <= S_IDLE;
      out_tvalid_r <= 1'b0;
      fs_r         <= 16'd48000;
      sb_r         <= 4'd8;
      nb_r         <= 5'd16;
      mode_r       <= sbc_bps_pkg::MODE_JOINT;
      moved_r      <= 2'd0;
      div_cnt_r    <= 6'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sbc_bps_pkg::CFG_SAMPLE_RATE: fs_r   <= cfg_data;
          sbc_bps_pkg::CFG_SUBBANDS:    sb_r   <= cfg_data[3:0];
          sbc_bps_pkg::CFG_BLOCKS:      nb_r   <= cfg_data[4:0];
          sbc_bps_pkg::CFG_CHAN_MODE:   mode_r <= cfg_data[1:0];
          default: ;
        endcase
      end
      // Drop the beat once taken, unless the next result loads this cycle.
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            rate_r  <= in_tdata[15:0];
            lo_r    <= in_tdata[23:16];
            hi_r    <= in_tdata[31:24];
            moved_r <= 2'd0;
            if (zero_div) begin
              pool_r  <= 16'd0;
              cause_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              state_r <= S_A_SETUP;
            end
          end
        end
        S_A_SETUP: begin
          div_dq_r  <= {6'd0, prod_a};
          div_rem_r <= 19'd0;
          div_den_r <= den_a;
          div_neg_r <= 1'b0;
          div_cnt_r <= 6'd36;
          div_ret_r <= S_B_SETUP;
          state_r   <= S_DIV;
        end
        S_B_SETUP: begin
          q1_r      <= div_q16;
          div_dq_r  <= {28'd0, num_b};
          div_rem_r <= 19'd0;
          div_den_r <= {14'd0, nb_r};
          div_neg_r <= 1'b0;
          div_cnt_r <= 6'd36;
          div_ret_r <= S_POOL;
          state_r   <= S_DIV;
        end
        S_POOL: begin
          pool_r  <= q1_r - div_q16;
          state_r <= stereo ? S_FRAME : S_DECIDE;
        end
        S_FRAME: begin
          frame_r <= frame_nxt;
          state_r <= S_C_SETUP;
        end
        S_C_SETUP: begin
          div_dq_r  <= mag_c;
          div_rem_r <= 19'd0;
          div_den_r <= den_c;
          div_neg_r <= num_c[35];
          div_cnt_r <= 6'd36;
          div_ret_r <= S_CHECK;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          div_rem_r <= rem_nxt;
          div_dq_r  <= {div_dq_r[34:0], rem_ge};
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == 6'd1) begin
            state_r <= div_ret_r;
          end
        end
        S_CHECK: begin
          // Lower the pool when the recomputed rate overshoots the target.
          if ($signed({div_q16[15], div_q16}) > $signed({1'b0, rate_r})) begin
            pool_r <= pool_r - 16'd1;
          end
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          moved_r <= moved_nxt;
          if ($signed(pool_r) > $signed({8'd0, hi_r})) begin
            rate_r <= rate_r - sbc_bps_pkg::RATE_STEP;
          end else if ($signed(pool_r) < $signed({8'd0, lo_r})) begin
            rate_r <= rate_up[15:0];
          end
          if (($signed(pool_r) <= $signed({8'd0, hi_r})) &&
              ($signed(pool_r) >= $signed({8'd0, lo_r}))) begin
            cause_r <= 1'b0;
            state_r <= S_DONE;
          end else if (moved_nxt == sbc_bps_pkg::MOVED_BOTH) begin
            cause_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_A_SETUP;
          end
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {7'd0, cause_r, rate_r, pool_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/sbc_bps_chk.sv =====
// Port-level checker for the bitpool search block, with its bind.
`include "sbc_bitpool_search_core_assert.svh"

module sbc_bps_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  `SBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SBC_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `SBC_ASSERT_IMPLY(a_in_range_pool, clk, rst_n, out_tvalid && !out_tdata[sbc_bps_pkg::OUT_CAUSE_BIT], out_tdata[15:8] == 8'd0)
  `SBC_ASSERT_IMPLY(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[39:33] == 7'd0)

endmodule

bind sbc_bitpool_search_core sbc_bps_chk u_sbc_bps_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
